// ===== hw/rtl/tts_pkg.sv =====
// tts_pkg: shared types, codes and helpers of the template tag scanner
// no dependencies; imported by tts_step and template_tag_scanner
package tts_pkg;

    localparam int POS_W = 24;            // byte offsets wrap at this width
    localparam int CNT_W = 24;            // line, column and error count width
    localparam int DEPTH = 4;             // lookahead bytes held
    localparam int MAX_RES = 4;           // results kept per word
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_SIGIL,
        MODE_BLANK
    } mode_t;

    localparam logic [3:0] K_NONE     = 4'd0;
    localparam logic [3:0] K_COMMENT  = 4'd1;
    localparam logic [3:0] K_VAR      = 4'd2;
    localparam logic [3:0] K_TRIPLE   = 4'd3;
    localparam logic [3:0] K_AMP      = 4'd4;
    localparam logic [3:0] K_SECTION  = 4'd5;
    localparam logic [3:0] K_INVERTED = 4'd6;
    localparam logic [3:0] K_CLOSE    = 4'd7;
    localparam logic [3:0] K_PARTIAL  = 4'd8;

    localparam logic [1:0] R_TAG   = 2'd0;
    localparam logic [1:0] R_ERROR = 2'd1;
    localparam logic [1:0] R_END   = 2'd2;

    localparam logic [1:0] E_DANGLING_OPEN  = 2'd0;
    localparam logic [1:0] E_DANGLING_CLOSE = 2'd1;
    localparam logic [1:0] E_BAD_CLOSE      = 2'd2;
    localparam logic [1:0] E_NO_NAME        = 2'd3;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef struct packed {
        logic [3:0]       kind;
        logic [CNT_W-1:0] line;
        logic [CNT_W-1:0] col;
        logic [POS_W-1:0] beg;
        logic [POS_W-1:0] wide_beg;
        logic             may_widen;
        logic [POS_W-1:0] label_at;
    } tag_t;

    typedef struct packed {
        mode_t                mode;
        logic [POS_W-1:0]     pos;
        logic [CNT_W-1:0]     line;
        logic [CNT_W-1:0]     col;
        logic [DEPTH-1:0][7:0] la;
        logic [2:0]           held;
        tag_t                 tag;
        logic [POS_W-1:0]     brs;        // start of current blank run
        logic                 rab;        // that run follows a break or the start
        logic [POS_W-1:0]     lnb;        // just past last non-blank
        logic [CNT_W-1:0]     err_total;
        logic [1:0]           cphase;     // closer sub-step
    } scan_t;

    typedef struct packed {
        logic [1:0]       rkind;
        logic [3:0]       tkind;
        logic [CNT_W-1:0] line;
        logic [CNT_W-1:0] col;
        logic [POS_W-1:0] sb;
        logic [POS_W-1:0] se;
        logic [POS_W-1:0] lb;
        logic [POS_W-1:0] le;
        logic [1:0]       ekind;
        logic [CNT_W-1:0] errs;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic logic is_break(input logic [7:0] c);
        return c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W-1){1'b0}}, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic scan_t reset_state();
        scan_t s;
        s           = '0;
        s.mode      = MODE_TEXT;
        s.line      = CNT_W'(1);
        s.col       = CNT_W'(1);
        s.tag.kind  = K_NONE;
        s.rab       = 1'b1;
        return s;
    endfunction

endpackage

// ===== hw/rtl/tts_step.sv =====
// tts_step: one scan step on the lookahead window, at most one result
// depends on tts_pkg
module tts_step import tts_pkg::*; (
    input  scan_t      st,
    input  logic       fresh,      // first step of a word: append its byte
    input  logic [7:0] data,
    input  logic       bv,
    input  logic       eot,
    output scan_t      nx,
    output logic       emit,
    output result_t    res,
    output logic       done        // word needs no further step
);

    logic [DEPTH-1:0][7:0] la;
    logic [2:0]       h;
    logic             cond;
    logic             has1;
    logic [1:0]       n;
    logic             in_tag;
    logic             end_rec;
    logic [3:0]       k;
    logic [CNT_W-1:0] col2;
    logic             brace3;
    logic             triple;
    logic             err2;
    logic             err3;
    logic [1:0]       p;
    logic [2:0]       used;
    logic [2:0]       idx;
    logic [POS_W-1:0] endv;
    logic [POS_W-1:0] pi;
    logic             widen;

    always_comb begin
        la      = st.la;
        h       = st.held;
        if (fresh && bv) begin
            la[h[1:0]] = data;
            h = h + 3'd1;
        end
        nx      = st;
        emit    = 1'b0;
        res     = '0;
        n       = 2'd0;
        end_rec = 1'b0;
        k       = K_VAR;
        used    = 3'd2;
        idx     = 3'd2;
        endv    = '0;
        pi      = '0;
        widen   = 1'b0;
        cond    = (h == 3'd4) || (eot && h != 3'd0);
        has1    = h > 3'd1;
        in_tag  = st.tag.kind != K_NONE && st.tag.kind != K_COMMENT;
        col2    = sat_add(st.col, 2'd2);
        brace3  = (h > 3'd2) && la[2] == CH_RBRACE;
        triple  = st.tag.kind == K_TRIPLE;
        err2    = triple && !brace3;
        err3    = st.tag.kind != K_COMMENT && st.lnb == st.tag.label_at;
        p       = st.cphase;
        if (p == 2'd0 && !err2) p = 2'd1;
        if (p == 2'd1 && !err3) p = 2'd2;

        if (!cond) begin
            if (eot) begin
                emit      = 1'b1;
                res.rkind = R_END;
                res.line  = st.line;
                res.col   = st.col;
                res.sb    = st.pos;
                res.se    = st.pos;
                res.errs  = st.err_total;
                end_rec   = 1'b1;
            end
        end else begin
            case (st.mode)
                MODE_SIGIL: begin
                    case (la[0])
                        CH_BANG:   k = K_COMMENT;
                        CH_LBRACE: k = K_TRIPLE;
                        CH_AMP:    k = K_AMP;
                        CH_HASH:   k = K_SECTION;
                        CH_CARET:  k = K_INVERTED;
                        CH_SLASH:  k = K_CLOSE;
                        CH_GT:     k = K_PARTIAL;
                        default:   k = K_VAR;
                    endcase
                    nx.tag.kind = k;
                    if (k != K_VAR) begin
                        n      = 2'd1;
                        nx.col = sat_add(st.col, 2'd1);
                    end
                    nx.mode = MODE_BLANK;
                end
                MODE_BLANK: begin
                    if (is_blank(la[0])) begin
                        n      = 2'd1;
                        nx.col = sat_add(st.col, 2'd1);
                    end else begin
                        nx.tag.label_at = st.pos;
                        nx.lnb          = st.pos;
                        nx.mode         = MODE_TEXT;
                    end
                end
                default: begin
                    if (has1 && la[0] == CH_LBRACE && la[1] == CH_LBRACE) begin
                        if (in_tag) begin
                            emit          = 1'b1;
                            res.rkind     = R_ERROR;
                            res.ekind     = E_DANGLING_OPEN;
                            res.line      = st.tag.line;
                            res.col       = st.tag.col;
                            nx.err_total  = sat_add(st.err_total, 2'd1);
                            nx.tag.kind   = K_NONE;
                        end
                        nx.tag.line      = st.line;
                        nx.tag.col       = st.col;
                        nx.tag.beg       = st.pos;
                        nx.tag.wide_beg  = st.brs;
                        nx.tag.may_widen = st.rab;
                        nx.col           = col2;
                        n                = 2'd2;
                        nx.mode          = MODE_SIGIL;
                    end else if (has1 && la[0] == CH_RBRACE && la[1] == CH_RBRACE) begin
                        if (st.tag.kind == K_NONE) begin
                            emit         = 1'b1;
                            res.rkind    = R_ERROR;
                            res.ekind    = E_DANGLING_CLOSE;
                            res.line     = st.line;
                            res.col      = st.col;
                            nx.err_total = sat_add(st.err_total, 2'd1);
                            n            = 2'd1;
                            nx.col       = sat_add(st.col, 2'd1);
                        end else begin
                            // closer: errors first, then the record, one per cycle when the step is not stalled
                            emit = 1'b1;
                            case (p)
                                2'd0: begin
                                    res.rkind    = R_ERROR;
                                    res.ekind    = E_BAD_CLOSE;
                                    res.line     = st.line;
                                    res.col      = col2;
                                    nx.err_total = sat_add(st.err_total, 2'd1);
                                    nx.cphase    = 2'd1;
                                end
                                2'd1: begin
                                    res.rkind    = R_ERROR;
                                    res.ekind    = E_NO_NAME;
                                    res.line     = st.tag.line;
                                    res.col      = st.tag.col;
                                    nx.err_total = sat_add(st.err_total, 2'd1);
                                    nx.cphase    = 2'd2;
                                end
                                default: begin
                                    used   = (triple && brace3) ? 3'd3 : 3'd2;
                                    nx.col = (triple && brace3) ? sat_add(col2, 2'd1) : col2;
                                    endv   = st.pos + POS_W'(used);
                                    res.sb = st.tag.beg;
                                    widen  = st.tag.kind != K_VAR && !triple
                                             && st.tag.kind != K_AMP && st.tag.may_widen
                                             && (used >= h || is_break(la[used[1:0]]));
                                    if (widen) begin
                                        res.sb = st.tag.wide_beg;
                                        idx    = used;
                                        if (idx < h && la[idx[1:0]] == CH_CR) begin
                                            endv = endv + POS_W'(1);
                                            idx  = idx + 3'd1;
                                        end
                                        if (idx < h && la[idx[1:0]] == CH_LF)
                                            endv = endv + POS_W'(1);
                                    end
                                    res.rkind   = R_TAG;
                                    res.tkind   = st.tag.kind;
                                    res.line    = st.tag.line;
                                    res.col     = st.tag.col;
                                    res.se      = endv;
                                    res.lb      = st.tag.label_at;
                                    res.le      = st.lnb;
                                    nx.tag.kind = K_NONE;
                                    n           = used[1:0];
                                    nx.cphase   = 2'd0;
                                end
                            endcase
                        end
                    end else if (is_break(la[0])) begin
                        n = (la[0] == CH_CR && has1 && la[1] == CH_LF) ? 2'd2 : 2'd1;
                        if (in_tag) begin
                            emit         = 1'b1;
                            res.rkind    = R_ERROR;
                            res.ekind    = E_DANGLING_OPEN;
                            res.line     = st.tag.line;
                            res.col      = st.tag.col;
                            nx.err_total = sat_add(st.err_total, 2'd1);
                            nx.tag.kind  = K_NONE;
                        end
                        nx.line = sat_add(st.line, 2'd1);
                        nx.col  = CNT_W'(1);
                    end else begin
                        n      = 2'd1;
                        nx.col = sat_add(st.col, 2'd1);
                    end
                end
            endcase
        end

        // consume n bytes from the window
        for (int i = 0; i < 3; i++) begin
            pi = st.pos + POS_W'(i + 1);
            if (2'(i) < n && !is_blank(la[i])) begin
                nx.brs = pi;
                nx.rab = is_break(la[i]);
                nx.lnb = pi;
            end
        end
        nx.pos  = st.pos + POS_W'(n);
        nx.la   = la >> {n, 3'b000};
        nx.held = h - {1'b0, n};

        if (end_rec)
            nx = reset_state();

        done = end_rec || (!eot && nx.held != 3'd4 && nx.cphase == 2'd0);
    end

endmodule

// ===== hw/rtl/template_tag_scanner.sv =====
// template_tag_scanner: top level, finds {{ }} tags in a byte stream
// depends on tts_pkg and tts_step
//
// channel | dir | tdata                 | tuser       | tlast
// s_      | in  | data_byte             | byte_valid  | end_of_template
// m_      | out | tag/error/end fields  | result_kind | run_last
//
// each word takes a step; each step that takes no byte comes on top: a plain var sigil,
// the first name byte, each closer error; a template's end adds its drain and record
// results pass a one-entry hold stage and an output register; one result
// waiting on m_tready leaves the input free, a second one in hold stalls it
// reset (aresetn low, synchronous) clears the scan state to line 1, column 1
// at most four results per word; further ones are dropped, but dropped errors still count in errors_seen
module template_tag_scanner import tts_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // byte_valid
    input  logic         s_tlast,   // end_of_template
    output logic         m_tvalid,
    input  logic         m_tready,
    // tag_kind[3:0] line_number[27:4] column_number[51:28] span_begin[75:52]
    // span_end[99:76] label_begin[123:100] label_end[147:124]
    // error_kind[149:148] errors_seen[173:150], zero fill [175:174]
    output logic [175:0] m_tdata,
    output logic [1:0]   m_tuser,   // result_kind
    output logic         m_tlast    // run_last
);

    scan_t      st_reg;
    scan_t      st_next;
    logic       in_v_reg;
    logic [7:0] in_data_reg;
    logic       in_bv_reg;
    logic       in_eot_reg;
    logic       fresh_reg;
    logic [2:0] nres_reg;
    logic       hold_v_reg;
    logic       hold_last_reg;
    result_t    hold_res_reg;
    logic       out_v_reg;
    logic       out_last_reg;
    result_t    out_res_reg;

    logic       step_emit;
    result_t    step_res;
    logic       step_done;
    logic       out_can;
    logic       go;
    logic       emit_ok;
    logic       hold_move;

    tts_step u_step (
        .st    (st_reg),
        .fresh (fresh_reg),
        .data  (in_data_reg),
        .bv    (in_bv_reg),
        .eot   (in_eot_reg),
        .nx    (st_next),
        .emit  (step_emit),
        .res   (step_res),
        .done  (step_done)
    );

    assign out_can   = !out_v_reg || m_tready;
    // step only when the hold slot can drain if needed
    assign go        = in_v_reg && (!hold_v_reg || out_can);
    assign emit_ok   = step_emit && (nres_reg < 3'(MAX_RES));
    // held result leaves once we know whether it ends its word
    assign hold_move = hold_v_reg && out_can
                       && (hold_last_reg || (go && (emit_ok || step_done)));
    assign s_tready  = !in_v_reg || (go && step_done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= reset_state();
            in_v_reg      <= 1'b0;
            fresh_reg     <= 1'b0;
            nres_reg      <= '0;
            hold_v_reg    <= 1'b0;
            hold_last_reg <= 1'b0;
            out_v_reg     <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            if (go)
                st_reg <= st_next;
            if (s_tvalid && s_tready) begin
                in_v_reg    <= 1'b1;
                in_data_reg <= s_tdata;
                in_bv_reg   <= s_tuser;
                in_eot_reg  <= s_tlast;
                fresh_reg   <= 1'b1;
                nres_reg    <= '0;
            end else if (go) begin
                fresh_reg <= 1'b0;
                if (emit_ok)
                    nres_reg <= nres_reg + 3'd1;
                if (step_done)
                    in_v_reg <= 1'b0;
            end

            if (go && emit_ok) begin
                hold_v_reg    <= 1'b1;
                hold_res_reg  <= step_res;
                hold_last_reg <= step_done;
            end else if (hold_move) begin
                hold_v_reg <= 1'b0;
            end

            if (out_can) begin
                out_v_reg    <= hold_move;
                out_res_reg  <= hold_res_reg;
                out_last_reg <= hold_last_reg || (go && step_done && !emit_ok);
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_res_reg.rkind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_res_reg.errs, out_res_reg.ekind,
                       out_res_reg.le, out_res_reg.lb, out_res_reg.se, out_res_reg.sb,
                       out_res_reg.col, out_res_reg.line, out_res_reg.tkind};

endmodule
